### sv/vole_pkg.sv
// Package: shared types, opcodes and sizes for the vole machine core.
package vole_pkg;

    localparam int MEM_DEPTH_DEFAULT = 256;
    localparam int ADDR_SPAN         = 256;
    localparam int REG_COUNT         = 16;
    localparam int REG_AW            = 4;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    localparam logic [3:0] OP_NONE  = 4'h0;
    localparam logic [3:0] OP_LOAD  = 4'h1;
    localparam logic [3:0] OP_LOADI = 4'h2;
    localparam logic [3:0] OP_STORE = 4'h3;
    localparam logic [3:0] OP_MOVE  = 4'h4;
    localparam logic [3:0] OP_ADD   = 4'h5;
    localparam logic [3:0] OP_JUMP  = 4'hB;
    localparam logic [3:0] OP_HALT  = 4'hC;

    localparam logic [7:0] PRINT_ADDR = 8'h00;

    typedef struct packed {
        logic       kind;
        logic [7:0] address;
        logic [7:0] data;
    } cmd_word_t;

    typedef struct packed {
        logic [7:0] pc;
        logic       halted;
        logic [3:0] opcode;
        logic       printed_valid;
        logic [7:0] printed_value;
    } result_word_t;

endpackage

### sv/vole_machine_core.sv
// Vole machine core: 8-bit machine with byte memory, register file and sequencer.
// A write word is accepted while busy is low and its result
// appears on result with done high in the next cycle. A step word runs through
// issue fetch, fetch second byte, decode and operand read, and execute;
// the single-port main memory supplies both instruction bytes and
// the load operand; a step while halted finishes like a write.
// Each result is shown for exactly one cycle and must be taken then.
// Memory and registers read as zero after reset without a clearing pass.
module vole_machine_core #(
    parameter int MEM_DEPTH = vole_pkg::MEM_DEPTH_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  vole_pkg::cmd_word_t     cmd,
    output logic                    busy,
    output logic                    done,
    output vole_pkg::result_word_t  result
);

    localparam int MEM_AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FETCH1 = 2'd1;
    localparam logic [1:0] ST_DECODE = 2'd2;
    localparam logic [1:0] ST_EXEC   = 2'd3;

    // address reduction table, built at elaboration
    logic [MEM_AW-1:0] idx_tab [vole_pkg::ADDR_SPAN];

    for (genvar idx_gen = 0; idx_gen < vole_pkg::ADDR_SPAN; idx_gen++)
    begin : g_idx_tab
        assign idx_tab[idx_gen] = MEM_AW'(idx_gen % MEM_DEPTH);
    end

    logic [7:0]           mem [MEM_DEPTH];
    logic                 mem_valid_reg [MEM_DEPTH];
    logic [7:0]           mem_rd_reg;
    logic                 mem_rd_valid_reg;

    logic [7:0]           rf [vole_pkg::REG_COUNT];
    logic                 rf_valid_reg [vole_pkg::REG_COUNT];
    logic [7:0]           rf_a_reg;
    logic [7:0]           rf_b_reg;
    logic                 rf_a_valid_reg;
    logic                 rf_b_valid_reg;

    logic [1:0]           state_reg, state_next;
    logic [7:0]           pc_reg, pc_next;
    logic                 halt_reg, halt_next;
    logic [7:0]           b0_reg, b0_next;
    logic [7:0]           b1_reg, b1_next;
    logic                 done_reg, done_next;
    vole_pkg::result_word_t result_reg, result_next;

    logic [7:0]                 mem_addr;
    logic [MEM_AW-1:0]          mem_idx;
    logic                       mem_we;
    logic [7:0]                 mem_wdata;
    logic [7:0]                 mem_out;

    logic [vole_pkg::REG_AW-1:0] rf_ra;
    logic [vole_pkg::REG_AW-1:0] rf_rb;
    logic                        rf_we;
    logic [vole_pkg::REG_AW-1:0] rf_waddr;
    logic [7:0]                  rf_wdata;
    logic [7:0]                  a_val;
    logic [7:0]                  b_val;

    logic                 accept;

    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign result  = result_reg;
    assign mem_idx = idx_tab[mem_addr];
    assign mem_out = mem_rd_valid_reg ? mem_rd_reg : 8'h00;
    assign a_val   = rf_a_valid_reg ? rf_a_reg : 8'h00;
    assign b_val   = rf_b_valid_reg ? rf_b_reg : 8'h00;

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        halt_next   = halt_reg;
        b0_next     = b0_reg;
        b1_next     = b1_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        mem_addr    = pc_reg;
        mem_we      = 1'b0;
        mem_wdata   = cmd.data;
        rf_ra       = b0_reg[3:0];
        rf_rb       = '0;
        rf_we       = 1'b0;
        rf_waddr    = b0_reg[3:0];
        rf_wdata    = b1_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.kind == vole_pkg::KIND_WRITE || halt_reg)
                    begin
                        if (cmd.kind == vole_pkg::KIND_WRITE)
                        begin
                            mem_addr = cmd.address;
                            mem_we   = 1'b1;
                        end
                        done_next                 = 1'b1;
                        result_next.pc            = pc_reg;
                        result_next.halted        = halt_reg;
                        result_next.opcode        = vole_pkg::OP_NONE;
                        result_next.printed_valid = 1'b0;
                        result_next.printed_value = 8'h00;
                    end
                    else
                    begin
                        mem_addr   = pc_reg;
                        state_next = ST_FETCH1;
                    end
                end
            end
            ST_FETCH1:
            begin
                b0_next    = mem_out;
                mem_addr   = pc_reg + 8'd1;
                state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                b1_next  = mem_out;
                mem_addr = mem_out;
                if (b0_reg[7:4] inside {vole_pkg::OP_MOVE, vole_pkg::OP_ADD})
                    rf_ra = mem_out[7:4];
                else
                    rf_ra = b0_reg[3:0];
                if (b0_reg[7:4] == vole_pkg::OP_ADD)
                    rf_rb = mem_out[3:0];
                else
                    rf_rb = '0;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                pc_next                   = pc_reg + 8'd2;
                result_next.opcode        = b0_reg[7:4];
                result_next.printed_valid = 1'b0;
                result_next.printed_value = 8'h00;
                mem_addr                  = b1_reg;
                mem_wdata                 = a_val;
                case (b0_reg[7:4])
                    vole_pkg::OP_LOAD:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = mem_out;
                    end
                    vole_pkg::OP_LOADI:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = b1_reg;
                    end
                    vole_pkg::OP_STORE:
                    begin
                        if (b1_reg == vole_pkg::PRINT_ADDR)
                        begin
                            result_next.printed_valid = 1'b1;
                            result_next.printed_value = a_val;
                        end
                        else
                            mem_we = 1'b1;
                    end
                    vole_pkg::OP_MOVE:
                    begin
                        rf_we    = 1'b1;
                        rf_waddr = b1_reg[3:0];
                        rf_wdata = a_val;
                    end
                    vole_pkg::OP_ADD:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = a_val + b_val;
                    end
                    vole_pkg::OP_JUMP:
                    begin
                        if (a_val == b_val)
                            pc_next = {b1_reg[7:1], 1'b0};
                    end
                    vole_pkg::OP_HALT:
                    begin
                        halt_next = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                result_next.pc     = pc_next;
                result_next.halted = halt_next;
                done_next          = 1'b1;
                state_next         = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // main memory array and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_idx] <= mem_wdata;
        mem_rd_reg <= mem[mem_idx];
    end

    // register file array and registered reads
    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf[rf_waddr] <= rf_wdata;
        rf_a_reg <= rf[rf_ra];
        rf_b_reg <= rf[rf_rb];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MEM_DEPTH; i++)
                mem_valid_reg[i] <= 1'b0;
            for (int i = 0; i < vole_pkg::REG_COUNT; i++)
                rf_valid_reg[i] <= 1'b0;
            mem_rd_valid_reg <= 1'b0;
            rf_a_valid_reg   <= 1'b0;
            rf_b_valid_reg   <= 1'b0;
            state_reg        <= ST_IDLE;
            pc_reg           <= 8'h00;
            halt_reg         <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            if (mem_we)
                mem_valid_reg[mem_idx] <= 1'b1;
            if (rf_we)
                rf_valid_reg[rf_waddr] <= 1'b1;
            mem_rd_valid_reg <= mem_valid_reg[mem_idx];
            rf_a_valid_reg   <= rf_valid_reg[rf_ra];
            rf_b_valid_reg   <= rf_valid_reg[rf_rb];
            state_reg        <= state_next;
            pc_reg           <= pc_next;
            halt_reg         <= halt_next;
            done_reg         <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b0_reg     <= b0_next;
        b1_reg     <= b1_next;
        result_reg <= result_next;
    end

    // a result follows either an accepted word or the execute cycle
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept || (state_reg == ST_EXEC)))
        else $error("result without a finishing word");

    // halt is sticky
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared");

    // fetch is entered only from idle
    a_fetch_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH1) |-> ($past(state_reg) == ST_IDLE))
        else $error("fetch entered from busy state");

    // printed value is zero unless printing
    a_print_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.printed_valid) |-> (result.printed_value == 8'h00))
        else $error("printed value without print");

endmodule
